// ===== sv/palette_nearest_color_cache_defines.svh =====
// Shared assertion macros; each expects i_clk and i_rst_n in scope.
`ifndef PALETTE_NEAREST_COLOR_CACHE_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_CACHE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define PNCC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define PNCC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/pncc_pkg.sv =====
package pncc_pkg;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_INVAL  = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_SLOT_RD,
        ST_SLOT_CHK,
        ST_SEARCH,
        ST_FILL,
        ST_PWR,
        ST_INVAL,
        ST_INV_END,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic mod_step;
        logic srch_start;
        logic take_hit;
        logic take_best;
        logic fill;
        logic pal_wr;
        logic inv_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic hit;
        logic srch_busy;
        logic inv_last;
        logic out_full;
    } t_sts;

endpackage

// ===== sv/palette_nearest_color_cache.sv =====
// Nearest palette color lookup with a direct-mapped answer cache.
// Input channel (i_in_valid / o_in_stall) takes one word per item: action,
// ARGB color, palette entry slot and owner id. Output channel
// (o_out_valid / i_out_stall) returns one word per item: match index and
// cache-hit flag. entry_count is written through i_cfg_we / i_cfg_data.
// One item is handled at a time. A lookup forms the slot index (byte
// fold, reciprocal multiply, subtract), then reads the slot; a hit answers
// from that read. A miss adds a scan of the palette memory, one entry per
// cycle, through a 3-stage read/square/compare pipe, then writes the slot.
// An invalidate walks every cache slot. After reset the cache is swept
// to zero with the input stalled. A stalled result sits in the output
// register; the block holds the next finished result until that word is taken.
module palette_nearest_color_cache #(
    parameter int CACHE_SLOTS   = 823,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_alpha,
    input  logic [7:0]  i_entry_slot,
    input  logic [31:0] i_owner_id,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_match_index,
    output logic        o_cache_hit
);

    pncc_pkg::t_cmd cmd;
    pncc_pkg::t_sts sts;

    // sequence the clear sweep and each item: index, probe, search, fill, palette write, invalidate, deliver
    pncc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // hold memories, counters, distance pipe and the output register
    pncc_datapath #(
        .CACHE_SLOTS   (CACHE_SLOTS),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_alpha       (i_alpha),
        .i_entry_slot  (i_entry_slot),
        .i_owner_id    (i_owner_id),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_match_index (o_match_index),
        .o_cache_hit   (o_cache_hit)
    );

endmodule

// ===== sv/pncc_ram.sv =====
module pncc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/pncc_ctrl.sv =====
module pncc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_action,
    input  pncc_pkg::t_sts   i_sts,
    output pncc_pkg::t_cmd   o_cmd,
    output logic             o_in_stall
);

    pncc_pkg::t_state r_state;
    pncc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pncc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pncc_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) n_state = pncc_pkg::ST_IDLE;
            end
            pncc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_action)
                        pncc_pkg::ACT_LOOKUP: n_state = pncc_pkg::ST_MOD;
                        pncc_pkg::ACT_WRITE:  n_state = pncc_pkg::ST_PWR;
                        pncc_pkg::ACT_INVAL:  n_state = pncc_pkg::ST_INVAL;
                        default:              n_state = pncc_pkg::ST_DONE;
                    endcase
                end
            end
            pncc_pkg::ST_MOD: begin
                if (i_sts.mod_last) n_state = pncc_pkg::ST_SLOT_RD;
            end
            pncc_pkg::ST_SLOT_RD:  n_state = pncc_pkg::ST_SLOT_CHK;
            pncc_pkg::ST_SLOT_CHK: begin
                n_state = i_sts.hit ? pncc_pkg::ST_DONE : pncc_pkg::ST_SEARCH;
            end
            pncc_pkg::ST_SEARCH: begin
                if (!i_sts.srch_busy) n_state = pncc_pkg::ST_FILL;
            end
            pncc_pkg::ST_FILL: n_state = pncc_pkg::ST_DONE;
            pncc_pkg::ST_PWR:  n_state = pncc_pkg::ST_DONE;
            pncc_pkg::ST_INVAL: begin
                if (i_sts.inv_last) n_state = pncc_pkg::ST_INV_END;
            end
            pncc_pkg::ST_INV_END: n_state = pncc_pkg::ST_DONE;
            pncc_pkg::ST_DONE: begin
                if (!i_sts.out_full) n_state = pncc_pkg::ST_IDLE;
            end
            default: n_state = pncc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            pncc_pkg::ST_CLEAR: o_cmd.clr_step = 1'b1;
            pncc_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            pncc_pkg::ST_MOD:      o_cmd.mod_step = 1'b1;
            pncc_pkg::ST_SLOT_RD:  ;
            pncc_pkg::ST_SLOT_CHK: begin
                o_cmd.take_hit   = i_sts.hit;
                o_cmd.srch_start = !i_sts.hit;
            end
            pncc_pkg::ST_SEARCH: ;
            pncc_pkg::ST_FILL: begin
                o_cmd.fill      = 1'b1;
                o_cmd.take_best = 1'b1;
            end
            pncc_pkg::ST_PWR:     o_cmd.pal_wr = 1'b1;
            pncc_pkg::ST_INVAL:   o_cmd.inv_step = 1'b1;
            pncc_pkg::ST_INV_END: ;
            pncc_pkg::ST_DONE:    o_cmd.out_load = !i_sts.out_full;
            default: ;
        endcase
    end

endmodule

// ===== sv/pncc_datapath.sv =====
`include "palette_nearest_color_cache_defines.svh"

module pncc_datapath #(
    parameter int CACHE_SLOTS   = 823,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    input  logic [7:0]       i_alpha,
    input  logic [7:0]       i_entry_slot,
    input  logic [31:0]      i_owner_id,
    input  logic             i_cfg_we,
    input  logic [8:0]       i_cfg_data,
    input  pncc_pkg::t_cmd   i_cmd,
    output pncc_pkg::t_sts   o_sts,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [7:0]       o_match_index,
    output logic             o_cache_hit
);

    localparam int SW  = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int PAW = $clog2(PALETTE_DEPTH);
    localparam int PCW = $clog2(PALETTE_DEPTH + 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(CACHE_SLOTS - 1);

    // slot index constants: 256^k mod CACHE_SLOTS per byte, then a
    // reciprocal exact for every folded value below 2^FW
    localparam int C1  = 256 % CACHE_SLOTS;
    localparam int C2  = (C1 * 256) % CACHE_SLOTS;
    localparam int C3  = (C2 * 256) % CACHE_SLOTS;
    localparam int FW  = $clog2(256 + 765 * CACHE_SLOTS);
    localparam int RSH = FW + $clog2(CACHE_SLOTS);
    localparam int PW  = 2 * FW + 1;
    localparam longint RECIP =
        ((longint'(1) << RSH) + longint'(CACHE_SLOTS - 1)) / longint'(CACHE_SLOTS);

    // captured item
    logic [31:0] r_argb;
    logic [31:0] r_owner;
    logic [7:0]  r_pos;
    logic [8:0]  r_count;

    // slot index: byte fold, reciprocal multiply, subtract; each step registered
    logic [31:0]       r_mval;
    logic [FW-1:0]     mod_fold;
    logic [FW-1:0]     r_fold;
    logic [PW-1:0]     r_prod;
    logic [PW-RSH-1:0] mod_quo;
    logic [FW-1:0]     mod_rem;
    logic [SW-1:0]     r_rem;
    logic [1:0]        r_bit;

    // sweep over the cache
    logic [SW-1:0] r_sweep;
    logic          r_inv_v;
    logic [SW-1:0] r_inv_addr;

    // cache memory
    logic          slot_we;
    logic [SW-1:0] slot_waddr;
    logic [71:0]   slot_wdata;
    logic [SW-1:0] slot_raddr;
    logic [71:0]   slot_rdata;

    // palette search
    logic [31:0]    pal_rdata;
    logic           pal_we;
    logic           r_srch;
    logic [PCW-1:0] r_issue;
    logic [PCW-1:0] r_limit;
    logic [PCW-1:0] lim;
    logic           issue;
    logic           r_v1;
    logic           r_v2;
    logic [PAW-1:0] r_idx1;
    logic [PAW-1:0] r_idx2;
    logic [PAW-1:0] r_best;
    logic signed [19:0] r_bdist;
    logic signed [8:0]  dr, dg, db, da;
    logic signed [17:0] pr, pg, pb, pa;
    logic [15:0]        r_sr, r_sg, r_sb, r_sa;
    logic signed [10:0] r_lin;
    logic signed [19:0] cur_dist;

    logic [7:0] r_ans;
    logic       r_hit;
    logic       hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_argb  <= {i_alpha, i_red, i_green, i_blue};
            r_owner <= i_owner_id;
            r_pos   <= i_entry_slot;
            r_mval  <= {i_alpha, i_red, i_green, i_blue} ^ i_owner_id;
            r_bit   <= '0;
        end else if (i_cmd.mod_step) begin
            r_bit <= r_bit + 2'd1;
        end
    end

    assign mod_fold = FW'(r_mval[7:0])
                    + FW'(r_mval[15:8])  * FW'(C1)
                    + FW'(r_mval[23:16]) * FW'(C2)
                    + FW'(r_mval[31:24]) * FW'(C3);
    assign mod_quo  = r_prod[PW-1:RSH];
    assign mod_rem  = r_fold - FW'(mod_quo) * FW'(CACHE_SLOTS);

    always_ff @(posedge i_clk) begin
        r_fold <= mod_fold;
        r_prod <= PW'(r_fold) * PW'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_cmd.mod_step && (r_bit == 2'd2)) begin
            r_rem <= mod_rem[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
            r_inv_v <= 1'b0;
        end else begin
            r_inv_v <= i_cmd.inv_step;
            if (i_cmd.clr_step || i_cmd.inv_step) begin
                r_sweep <= (r_sweep == SLOT_LAST) ? '0 : r_sweep + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_inv_addr <= r_sweep;
    end

    assign slot_raddr = i_cmd.inv_step ? r_sweep : r_rem;

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_rem;
        slot_wdata = {r_owner, r_argb, 8'(r_best)};
        priority if (i_cmd.clr_step) begin
            slot_we    = 1'b1;
            slot_waddr = r_sweep;
            slot_wdata = '0;
        end else if (r_inv_v) begin
            slot_we    = (slot_rdata[71:40] == r_owner);
            slot_waddr = r_inv_addr;
            slot_wdata = {32'd0, slot_rdata[39:0]};
        end else begin
            slot_we = i_cmd.fill;
        end
    end

    pncc_ram #(.WIDTH(72), .DEPTH(CACHE_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    assign hit = (slot_rdata[71:40] == r_owner) && (slot_rdata[39:8] == r_argb);

    assign pal_we = i_cmd.pal_wr && ({1'b0, r_pos} < 9'(PALETTE_DEPTH));

    pncc_ram #(.WIDTH(32), .DEPTH(PALETTE_DEPTH)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (r_pos[PAW-1:0]),
        .i_wdata (r_argb),
        .i_raddr (r_issue[PAW-1:0]),
        .o_rdata (pal_rdata)
    );

    assign lim   = (r_count > 9'(PALETTE_DEPTH)) ? PCW'(PALETTE_DEPTH) : r_count[PCW-1:0];
    assign issue = r_srch && (r_issue != r_limit);

    // stage 1: differences and squares of the entry read last cycle
    assign dr = $signed({1'b0, pal_rdata[23:16]}) - $signed({1'b0, r_argb[23:16]});
    assign dg = $signed({1'b0, pal_rdata[15:8]})  - $signed({1'b0, r_argb[15:8]});
    assign db = $signed({1'b0, pal_rdata[7:0]})   - $signed({1'b0, r_argb[7:0]});
    assign da = $signed({1'b0, pal_rdata[31:24]}) - $signed({1'b0, r_argb[31:24]});
    assign pr = dr * dr;
    assign pg = dg * dg;
    assign pb = db * db;
    assign pa = da * da;

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_issue[PAW-1:0];
        r_idx2 <= r_idx1;
        r_sr   <= pr[15:0];
        r_sg   <= pg[15:0];
        r_sb   <= pb[15:0];
        r_sa   <= pa[15:0];
        r_lin  <= 11'(dr) + 11'(dg) + 11'(db);
    end

    // stage 2: distance and running minimum
    assign cur_dist = (r_argb[31:24] != 8'd0)
        ? $signed({4'd0, r_sr} + {4'd0, r_sg} + {4'd0, r_sb} + {10'd0, r_sa[15:6]})
        : $signed({{9{r_lin[10]}}, r_lin}) + $signed({4'd0, r_sa});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srch <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else if (i_cmd.srch_start) begin
            r_srch  <= 1'b1;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_issue <= '0;
            r_limit <= lim;
            r_best  <= '0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1 && r_srch;
            if (issue) begin
                r_issue <= r_issue + PCW'(1);
            end
            if (r_v2 && r_srch) begin
                if ((r_idx2 == '0) || (cur_dist < r_bdist)) begin
                    r_best  <= r_idx2;
                    r_bdist <= cur_dist;
                end
                if (cur_dist == 20'sd0) begin
                    r_srch <= 1'b0;
                end
            end
            if (!issue && !r_v1 && !r_v2) begin
                r_srch <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ans <= '0;
            r_hit <= 1'b0;
        end else if (i_cmd.take_hit) begin
            r_ans <= slot_rdata[7:0];
            r_hit <= 1'b1;
        end else if (i_cmd.take_best) begin
            r_ans <= 8'(r_best);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_match_index <= r_ans;
            o_cache_hit   <= r_hit;
        end
    end

    assign o_sts.clr_last  = (r_sweep == SLOT_LAST);
    assign o_sts.inv_last  = (r_sweep == SLOT_LAST);
    assign o_sts.mod_last  = (r_bit == 2'd2);
    assign o_sts.hit       = hit;
    assign o_sts.srch_busy = r_srch;
    assign o_sts.out_full  = o_out_valid && i_out_stall;

    `PNCC_ASSERT_ALWAYS(a_rem_range, {1'b0, r_rem} < (SW+1)'(CACHE_SLOTS), "slot index out of range")
    `PNCC_ASSERT_IMPLY(a_issue_lim, issue, r_issue < r_limit, "palette read past entry count")
    `PNCC_ASSERT_IMPLY(a_fill_done, i_cmd.fill, !r_srch, "slot filled while search runs")

endmodule

// ===== dv/palette_checker.sv =====
`timescale 1ns / 1ps

module palette_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_alpha,
    input  logic [7:0]  i_entry_slot,
    input  logic [31:0] i_owner_id,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_match_index,
    input  logic        i_cache_hit,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NUM_SLOTS = 823;
    localparam int PAL_DEPTH = 256;
    localparam int ALPHA_SHIFT = 6;

    typedef struct packed {
        logic [7:0] index;
        logic       hit;
    } t_answer;

    logic [31:0] pal_color [PAL_DEPTH];
    logic [31:0] tag_owner [NUM_SLOTS];
    logic [31:0] tag_color [NUM_SLOTS];
    logic [7:0]  tag_answer [NUM_SLOTS];
    logic [8:0]  search_len;
    t_answer     answer_q [$];
    int          fails;

    // Linear nearest-entry search over the first search_len entries, capped at PAL_DEPTH.
    function automatic logic [7:0] nearest_index(logic [31:0] argb);
        int limit;
        int best;
        int best_d;
        int d;
        int dr, dg, db, da;
        bit stop;
        limit = (search_len > PAL_DEPTH) ? PAL_DEPTH : int'(search_len);
        best = 0;
        best_d = 0;
        stop = 0;
        for (int i = 0; i < limit; i++) begin
            if (!stop) begin
                dr = int'(pal_color[i][23:16]) - int'(argb[23:16]);
                dg = int'(pal_color[i][15:8]) - int'(argb[15:8]);
                db = int'(pal_color[i][7:0]) - int'(argb[7:0]);
                da = int'(pal_color[i][31:24]) - int'(argb[31:24]);
                if (argb[31:24] != 8'd0)
                    d = dr * dr + dg * dg + db * db + ((da * da) >> ALPHA_SHIFT);
                else
                    d = dr + dg + db + da * da;
                if (i == 0 || d < best_d) begin
                    best_d = d;
                    best = i;
                end
                if (d == 0)
                    stop = 1;
            end
        end
        return best[7:0];
    endfunction

    function automatic t_answer cache_lookup(logic [1:0] act, logic [31:0] argb,
                                             logic [7:0] pos, logic [31:0] owner);
        t_answer res;
        int unsigned slot;
        res = '0;
        if (act == pncc_pkg::ACT_LOOKUP) begin
            slot = (argb ^ owner) % 32'd823;
            if (tag_owner[slot] == owner && tag_color[slot] == argb) begin
                res.index = tag_answer[slot];
                res.hit = 1'b1;
            end else begin
                res.index = nearest_index(argb);
                tag_owner[slot] = owner;
                tag_color[slot] = argb;
                tag_answer[slot] = res.index;
            end
        end else if (act == pncc_pkg::ACT_WRITE) begin
            pal_color[pos] = argb;
        end else if (act == pncc_pkg::ACT_INVAL) begin
            for (int s = 0; s < NUM_SLOTS; s++)
                if (tag_owner[s] == owner)
                    tag_owner[s] = '0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                tag_owner[s] = '0;
                tag_color[s] = '0;
                tag_answer[s] = '0;
            end
            for (int i = 0; i < PAL_DEPTH; i++)
                pal_color[i] = '0;
            search_len = '0;
            answer_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_we)
                search_len = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                answer_q.push_back(cache_lookup(i_action,
                    {i_alpha, i_red, i_green, i_blue}, i_entry_slot, i_owner_id));
            if (i_out_valid && !i_out_stall) begin
                got.index = i_match_index;
                got.hit = i_cache_hit;
                if (answer_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result word: index %0d hit %0d",
                                 got.index, got.hit);
                end else begin
                    want = answer_q.pop_front();
                    if (got.index !== want.index || got.hit !== want.hit) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected index %0d hit %0d, got index %0d hit %0d",
                                     want.index, want.hit, got.index, got.hit);
                    end
                end
            end
        end
        o_fail_count <= fails + answer_q.size();
        o_pending <= answer_q.size();
    end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Action code with no function; the block answers zeros.
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int PHASE_ITEMS = 85;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_action = '0;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic [7:0]  i_alpha = '0;
    logic [7:0]  i_entry_slot = '0;
    logic [31:0] i_owner_id = '0;
    logic        i_cfg_we = 1'b0;
    logic [8:0]  i_cfg_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_match_index;
    logic        o_cache_hit;

    int fail_count;
    int pending;

    // Stimulus-side copy of palette colors, used only to aim queries at entries.
    logic [31:0] pal_shadow [256];
    logic [31:0] recent_argb [$];
    logic [31:0] recent_owner [$];
    int          burst_left = 0;
    bit          hold_req = 0;

    always #6 i_clk = ~i_clk;

    palette_nearest_color_cache DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_action(i_action), .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .i_alpha(i_alpha), .i_entry_slot(i_entry_slot), .i_owner_id(i_owner_id),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_match_index(o_match_index), .o_cache_hit(o_cache_hit)
    );

    palette_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_action(i_action), .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .i_alpha(i_alpha), .i_entry_slot(i_entry_slot), .i_owner_id(i_owner_id),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_match_index(o_match_index), .i_cache_hit(o_cache_hit),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: stall in a randomly picked mode; one long hold on request.
    always @(posedge i_clk) begin
        static int cyc = 0;
        static int mode = 0;
        static int hold_left = 0;
        static bit hold_done = 0;
        if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
        end
        if (cyc % 64 == 0)
            mode = $urandom_range(0, 3);
        cyc++;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        static int quiet = 0;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one word and hold it until accepted; insert a random gap, which may be empty, before each burst.
    task automatic send_word(logic [1:0] act, logic [31:0] argb, logic [7:0] pos,
                             logic [31:0] owner);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_action <= act;
        {i_alpha, i_red, i_green, i_blue} <= argb;
        i_entry_slot <= pos;
        i_owner_id <= owner;
        do @(posedge i_clk); while (o_in_stall);
        if (act == pncc_pkg::ACT_WRITE)
            pal_shadow[pos] = argb;
        if (act == pncc_pkg::ACT_LOOKUP) begin
            recent_argb.push_back(argb);
            recent_owner.push_back(owner);
            if (recent_argb.size() > 16) begin
                void'(recent_argb.pop_front());
                void'(recent_owner.pop_front());
            end
        end
    endtask

    // Drain every expected word, then write the entry count.
    task automatic set_entry_count(logic [8:0] value);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_owner();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'hA5A5_5A5A;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_word();
        int r;
        int k;
        logic [31:0] argb;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            // Reuse a recent query for hits, aim at a palette color, or go random.
            k = $urandom_range(0, 9);
            if (k < 4 && recent_argb.size() > 0) begin
                k = $urandom_range(0, recent_argb.size() - 1);
                send_word(pncc_pkg::ACT_LOOKUP, recent_argb[k], 8'($urandom),
                          recent_owner[k]);
            end else begin
                argb = (k < 7) ? pal_shadow[$urandom_range(0, 255)] : $urandom;
                if ($urandom_range(0, 6) == 0)
                    argb[31:24] = 8'd0;
                send_word(pncc_pkg::ACT_LOOKUP, argb, 8'($urandom), pick_owner());
            end
        end else if (r < 82) begin
            send_word(pncc_pkg::ACT_WRITE, $urandom, 8'($urandom), $urandom);
        end else if (r < 90) begin
            send_word(pncc_pkg::ACT_INVAL, $urandom, 8'($urandom), pick_owner());
        end else if (r < 95) begin
            send_word(ACT_NONE, $urandom, 8'($urandom), $urandom);
        end else begin
            send_word(pncc_pkg::ACT_LOOKUP, $urandom, 8'($urandom), $urandom);
        end
    endtask

    initial begin
        logic [8:0] counts [9];
        counts = '{9'd1, 9'd8, 9'd256, 9'd511, 9'd3, 9'd17, 9'd255, 9'd2, 9'd0};
        for (int i = 0; i < 256; i++)
            pal_shadow[i] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty palette: black with owner zero hits the never-filled slot 0.
        send_word(pncc_pkg::ACT_LOOKUP, 32'h0000_0000, 8'h00, 32'h0000_0000);
        send_word(pncc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send_word(pncc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send_word(pncc_pkg::ACT_INVAL, 32'h0, 8'h0, 32'hFFFF_FFFF);
        send_word(pncc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        // Invalidating id zero leaves slot 0 alone.
        send_word(pncc_pkg::ACT_INVAL, 32'hFFFF_FFFF, 8'hFF, 32'h0000_0000);
        send_word(pncc_pkg::ACT_LOOKUP, 32'h0000_0000, 8'h00, 32'h0000_0000);
        send_word(ACT_NONE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send_word(ACT_NONE, 32'h0, 8'h0, 32'h0);

        // Load the whole palette so any entry count is safe to search.
        send_word(pncc_pkg::ACT_WRITE, 32'h0000_0000, 8'd0, 32'h0);
        send_word(pncc_pkg::ACT_WRITE, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
        for (int i = 1; i < 255; i++)
            send_word(pncc_pkg::ACT_WRITE, $urandom, i[7:0], $urandom);

        for (int p = 0; p < 9; p++) begin
            set_entry_count(counts[p]);
            if (p == 1)
                hold_req = 1;
            if (p == 2) begin
                // Exact matches, alpha-zero queries (signed distance) and repeats.
                send_word(pncc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 8'h00, 32'h0000_0007);
                send_word(pncc_pkg::ACT_LOOKUP, 32'h00FF_FFFF, 8'h00, 32'h0000_0007);
                send_word(pncc_pkg::ACT_LOOKUP, 32'h0000_0000, 8'h00, 32'h0000_0007);
                send_word(pncc_pkg::ACT_LOOKUP, pal_shadow[128], 8'h00, 32'h0000_0007);
                send_word(pncc_pkg::ACT_LOOKUP, pal_shadow[128], 8'h00, 32'h0000_0007);
                send_word(pncc_pkg::ACT_WRITE, 32'h1234_5678, 8'd128, 32'h0);
                send_word(pncc_pkg::ACT_LOOKUP, pal_shadow[128], 8'h00, 32'h0000_0007);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_word();
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
